### design/osett_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osett_pkg
// Shared types and constants of the one-shot event timer table.
// ----------------------------------------------------------------------------
package osett_pkg;

	localparam int SLOTS       = 10;
	localparam int MAX_RESULTS = 10;
	localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int ID_W        = 8;
	localparam int TIME_W      = 64;
	localparam int SLOT_OUT_W  = 4;

	typedef enum logic [1:0] {
		KIND_REGISTER   = 2'd0,
		KIND_UNREGISTER = 2'd1,
		KIND_SCHEDULE   = 2'd2,
		KIND_TICK       = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Slot numbers are reported masked to the width of the result field.
	function automatic logic [SLOT_OUT_W-1:0] to_slot_index(input logic [IDX_W-1:0] idx);
		logic [IDX_W+SLOT_OUT_W-1:0] wide;
		wide = {{SLOT_OUT_W{1'b0}}, idx};
		return wide[SLOT_OUT_W-1:0];
	endfunction

endpackage
`default_nettype wire

### design/one_shot_event_timer_table.sv
`default_nettype none
// Flow: a request is taken in ST_IDLE, then ST_SCAN visits the slots one per cycle (a schedule
// stops at its first match; a tick stalls while a held fired result waits for a free sink),
// and ST_FINISH writes the final result once the sink is free. No new request is taken until
// ST_FINISH is done; there is a single slot walker and one 64-bit due-time comparator.
// Reset: arst_n clears all used and armed marks and the handshake state at once.
// ----------------------------------------------------------------------------
// one_shot_event_timer_table
// Table of one-shot event timers with register, unregister, schedule and tick requests.
// ----------------------------------------------------------------------------
module one_shot_event_timer_table (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          kind,
	input  wire logic [osett_pkg::ID_W-1:0]          event_id,
	input  wire logic [osett_pkg::TIME_W-1:0]        time_value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     accepted,
	output logic [osett_pkg::SLOT_OUT_W-1:0]         slot_index,
	output logic                                     fired,
	output logic [osett_pkg::ID_W-1:0]               fired_id,
	output logic [osett_pkg::TIME_W-1:0]             fired_time,
	output logic                                     last
);

	osett_pkg::state_t state_q, state_d;

	logic [osett_pkg::SLOTS-1:0]       used_q;
	logic [osett_pkg::SLOTS-1:0]       armed_q;
	logic [osett_pkg::ID_W-1:0]        event_q [osett_pkg::SLOTS];
	logic [osett_pkg::TIME_W-1:0]      due_q   [osett_pkg::SLOTS];

	osett_pkg::kind_t                  kind_q;
	logic [osett_pkg::ID_W-1:0]        id_q;
	logic [osett_pkg::TIME_W-1:0]      time_q;
	logic [osett_pkg::IDX_W-1:0]       idx_q;
	logic [osett_pkg::IDX_W-1:0]       sel_q;
	logic                              found_q;
	logic [osett_pkg::SLOTS-1:0]       mask_q;
	logic [osett_pkg::CNT_W-1:0]       cnt_q;

	logic                              pend_valid_q;
	logic [osett_pkg::ID_W-1:0]        pend_id_q;
	logic [osett_pkg::TIME_W-1:0]      pend_time_q;

	logic                              out_valid_q;
	logic                              out_acc_q;
	logic [osett_pkg::SLOT_OUT_W-1:0]  out_slot_q;
	logic                              out_fired_q;
	logic [osett_pkg::ID_W-1:0]        out_id_q;
	logic [osett_pkg::TIME_W-1:0]      out_time_q;
	logic                              out_last_q;

	logic in_take;
	logic out_free;
	logic last_idx;
	logic cur_match;
	logic tick_hit;
	logic step;
	logic emit_pend;
	logic fin_load;
	logic sched_stop;

	assign in_take   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign last_idx  = (idx_q == osett_pkg::IDX_W'(osett_pkg::SLOTS - 1));
	assign cur_match = used_q[idx_q] && (event_q[idx_q] == id_q);
	assign tick_hit  = used_q[idx_q] && armed_q[idx_q] && (time_q >= due_q[idx_q])
		&& (cnt_q < osett_pkg::CNT_W'(osett_pkg::MAX_RESULTS));

	// Sequencer control.
	always_comb begin
		in_ready   = (state_q == osett_pkg::ST_IDLE);
		step       = 1'b0;
		emit_pend  = 1'b0;
		fin_load   = 1'b0;
		sched_stop = 1'b0;
		unique case (state_q)
			osett_pkg::ST_IDLE: begin
			end
			osett_pkg::ST_SCAN: begin
				if (kind_q == osett_pkg::KIND_TICK && tick_hit && pend_valid_q) begin
					// A second expired slot pushes the held one out, so the sink must be free.
					step      = out_free;
					emit_pend = out_free;
				end else begin
					step = 1'b1;
				end
				sched_stop = (kind_q == osett_pkg::KIND_SCHEDULE) && cur_match;
			end
			osett_pkg::ST_FINISH: begin
				fin_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			osett_pkg::ST_IDLE: begin
				if (in_take) begin
					state_d = osett_pkg::ST_SCAN;
				end
			end
			osett_pkg::ST_SCAN: begin
				if (step && (last_idx || sched_stop)) begin
					state_d = osett_pkg::ST_FINISH;
				end
			end
			osett_pkg::ST_FINISH: begin
				if (fin_load) begin
					state_d = osett_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = osett_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= osett_pkg::ST_IDLE;
			used_q       <= '0;
			armed_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_load || emit_pend) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == osett_pkg::ST_SCAN && step) begin
				unique case (kind_q)
					osett_pkg::KIND_UNREGISTER: begin
						if (cur_match) begin
							used_q[idx_q]  <= 1'b0;
							armed_q[idx_q] <= 1'b0;
						end
					end
					osett_pkg::KIND_TICK: begin
						if (tick_hit) begin
							armed_q[idx_q] <= 1'b0;
							pend_valid_q   <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (fin_load) begin
				pend_valid_q <= 1'b0;
				if (found_q && kind_q == osett_pkg::KIND_REGISTER) begin
					used_q[sel_q] <= 1'b1;
					armed_q       <= armed_q & ~mask_q;
				end
				if (found_q && kind_q == osett_pkg::KIND_SCHEDULE) begin
					armed_q[sel_q] <= 1'b1;
				end
			end
		end
	end

	// Payload, slot contents and scan bookkeeping.
	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_q  <= osett_pkg::kind_t'(kind);
			id_q    <= event_id;
			time_q  <= time_value;
			idx_q   <= '0;
			sel_q   <= '0;
			found_q <= 1'b0;
			mask_q  <= '0;
			cnt_q   <= '0;
		end
		if (state_q == osett_pkg::ST_SCAN && step) begin
			if (!last_idx) begin
				idx_q <= idx_q + osett_pkg::IDX_W'(1);
			end
			unique case (kind_q)
				osett_pkg::KIND_REGISTER: begin
					if (!used_q[idx_q] && !found_q) begin
						found_q <= 1'b1;
						sel_q   <= idx_q;
					end
					if (cur_match) begin
						mask_q[idx_q] <= 1'b1;
					end
				end
				osett_pkg::KIND_SCHEDULE: begin
					if (cur_match) begin
						found_q <= 1'b1;
						sel_q   <= idx_q;
					end
				end
				osett_pkg::KIND_TICK: begin
					if (tick_hit) begin
						pend_id_q   <= event_q[idx_q];
						pend_time_q <= due_q[idx_q];
						cnt_q       <= cnt_q + osett_pkg::CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
		if (fin_load && found_q) begin
			if (kind_q == osett_pkg::KIND_REGISTER) begin
				event_q[sel_q] <= id_q;
			end
			if (kind_q == osett_pkg::KIND_SCHEDULE) begin
				due_q[sel_q] <= time_q;
			end
		end
		if (emit_pend) begin
			out_acc_q   <= 1'b0;
			out_slot_q  <= '0;
			out_fired_q <= 1'b1;
			out_id_q    <= pend_id_q;
			out_time_q  <= pend_time_q;
			out_last_q  <= 1'b0;
		end else if (fin_load) begin
			out_last_q <= 1'b1;
			if (kind_q == osett_pkg::KIND_TICK) begin
				out_acc_q   <= 1'b0;
				out_slot_q  <= '0;
				out_fired_q <= pend_valid_q;
				out_id_q    <= pend_valid_q ? pend_id_q : '0;
				out_time_q  <= pend_valid_q ? pend_time_q : '0;
			end else begin
				out_acc_q   <= found_q || (kind_q == osett_pkg::KIND_UNREGISTER);
				out_slot_q  <= (found_q && kind_q != osett_pkg::KIND_UNREGISTER)
					? osett_pkg::to_slot_index(sel_q) : '0;
				out_fired_q <= 1'b0;
				out_id_q    <= '0;
				out_time_q  <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign accepted   = out_acc_q;
	assign slot_index = out_slot_q;
	assign fired      = out_fired_q;
	assign fired_id   = out_id_q;
	assign fired_time = out_time_q;
	assign last       = out_last_q;

endmodule
`default_nettype wire

### tb/sv/one_shot_event_timer_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// one_shot_event_timer_table_test
// Drives register, unregister, schedule and tick requests into the timer table
// and checks results against a slot-level predictor or typed row values. A
// short table of directed requests comes first, then random traffic with
// bursty requests, a stalling sink, one long hold-off that backs up the block.
// ----------------------------------------------------------------------------
module one_shot_event_timer_table_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 150;
	localparam int DRAIN_CYCLES   = 4 * (osett_pkg::SLOTS + 2);
	localparam int RANDOM_COUNT   = 84;
	localparam logic [osett_pkg::TIME_W-1:0] TIME_MAX = {osett_pkg::TIME_W{1'b1}};

	typedef struct packed {
		logic                             acc;
		logic [osett_pkg::SLOT_OUT_W-1:0] idx;
		logic                             fire;
		logic [osett_pkg::ID_W-1:0]       fid;
		logic [osett_pkg::TIME_W-1:0]     ftime;
		logic                             lst;
	} timer_report_t;

	typedef struct {
		osett_pkg::kind_t             k;
		logic [osett_pkg::ID_W-1:0]   id;
		logic [osett_pkg::TIME_W-1:0] t;
		bit                           typed;
		timer_report_t                want;
	} stim_row_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic [1:0]                       kind = osett_pkg::KIND_REGISTER;
	logic [osett_pkg::ID_W-1:0]       event_id = '0;
	logic [osett_pkg::TIME_W-1:0]     time_value = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic                             accepted;
	logic [osett_pkg::SLOT_OUT_W-1:0] slot_index;
	logic                             fired;
	logic [osett_pkg::ID_W-1:0]       fired_id;
	logic [osett_pkg::TIME_W-1:0]     fired_time;
	logic                             last;

	// Shadow copy of the slot table.
	logic                         tbl_used[osett_pkg::SLOTS];
	logic [osett_pkg::ID_W-1:0]   tbl_event[osett_pkg::SLOTS];
	logic                         tbl_armed[osett_pkg::SLOTS];
	logic [osett_pkg::TIME_W-1:0] tbl_due[osett_pkg::SLOTS];

	timer_report_t pending_reports[$];
	stim_row_t     directed_rows[$];
	int            mismatch_count = 0;
	int            burst_left = 0;
	bit            backpressure_start = 1'b0;

	one_shot_event_timer_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.event_id   (event_id),
		.time_value (time_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.accepted   (accepted),
		.slot_index (slot_index),
		.fired      (fired),
		.fired_id   (fired_id),
		.fired_time (fired_time),
		.last       (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Updates the shadow table for one request and, when record is set, queues
	// the results that the request should produce.
	task automatic predict_request(input osett_pkg::kind_t k,
	                               input logic [osett_pkg::ID_W-1:0] id,
	                               input logic [osett_pkg::TIME_W-1:0] t, input bit record);
		int            i;
		int            j;
		int            free_slot;
		int            n;
		int            hits[osett_pkg::MAX_RESULTS];
		timer_report_t r;
		free_slot = -1;
		n = 0;
		r = '0;
		r.lst = 1'b1;
		case (k)
			osett_pkg::KIND_REGISTER: begin
				for (i = 0; i < osett_pkg::SLOTS; i++)
					if (!tbl_used[i] && free_slot < 0)
						free_slot = i;
				if (free_slot >= 0) begin
					tbl_used[free_slot] = 1'b1;
					tbl_event[free_slot] = id;
					// A repeated id disarms every slot that holds it.
					for (i = 0; i < osett_pkg::SLOTS; i++)
						if (tbl_used[i] && tbl_event[i] == id)
							tbl_armed[i] = 1'b0;
					r.acc = 1'b1;
					r.idx = osett_pkg::SLOT_OUT_W'(free_slot);
				end
				if (record)
					pending_reports.push_back(r);
			end
			osett_pkg::KIND_UNREGISTER: begin
				for (i = 0; i < osett_pkg::SLOTS; i++)
					if (tbl_used[i] && tbl_event[i] == id) begin
						tbl_used[i] = 1'b0;
						tbl_armed[i] = 1'b0;
					end
				r.acc = 1'b1;
				if (record)
					pending_reports.push_back(r);
			end
			osett_pkg::KIND_SCHEDULE: begin
				for (i = 0; i < osett_pkg::SLOTS; i++)
					if (tbl_used[i] && tbl_event[i] == id && !r.acc) begin
						tbl_due[i] = t;
						tbl_armed[i] = 1'b1;
						r.acc = 1'b1;
						r.idx = osett_pkg::SLOT_OUT_W'(i);
					end
				if (record)
					pending_reports.push_back(r);
			end
			default: begin
				for (i = 0; i < osett_pkg::SLOTS && n < osett_pkg::MAX_RESULTS; i++)
					if (tbl_used[i] && tbl_armed[i] && t >= tbl_due[i]) begin
						tbl_armed[i] = 1'b0;
						hits[n] = i;
						n++;
					end
				if (record && n == 0)
					pending_reports.push_back(r);
				for (j = 0; j < n && record; j++) begin
					r.fire = 1'b1;
					r.fid = tbl_event[hits[j]];
					r.ftime = tbl_due[hits[j]];
					r.lst = (j == n - 1);
					pending_reports.push_back(r);
				end
			end
		endcase
	endtask

	// Offers one request and holds it until taken; bursts end in a random gap.
	task automatic issue_request(input osett_pkg::kind_t k,
	                             input logic [osett_pkg::ID_W-1:0] id,
	                             input logic [osett_pkg::TIME_W-1:0] t, input bit typed,
	                             input timer_report_t want);
		in_valid <= 1'b1;
		kind <= k;
		event_id <= id;
		time_value <= t;
		do
			@(posedge clk);
		while (!in_ready);
		predict_request(k, id, t, !typed);
		if (typed)
			pending_reports.push_back(want);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 7);
		end
	endtask

	task automatic add_row(input osett_pkg::kind_t k, input logic [osett_pkg::ID_W-1:0] id,
	                       input logic [osett_pkg::TIME_W-1:0] t, input bit typed,
	                       input logic acc, input logic [osett_pkg::SLOT_OUT_W-1:0] idx);
		stim_row_t row;
		row.k = k;
		row.id = id;
		row.t = t;
		row.typed = typed;
		row.want = '0;
		row.want.acc = acc;
		row.want.idx = idx;
		row.want.lst = 1'b1;
		directed_rows.push_back(row);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
	                           input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : result_monitor
		timer_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("result arrived with no request outstanding");
				mismatch_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("accepted", 64'(want.acc), 64'(accepted));
				check_field("slot_index", 64'(want.idx), 64'(slot_index));
				check_field("fired", 64'(want.fire), 64'(fired));
				check_field("fired_id", 64'(want.fid), 64'(fired_id));
				check_field("fired_time", want.ftime, fired_time);
				check_field("last", 64'(want.lst), 64'(last));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		int idle_cycles;
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// The sink switches between stall patterns and holds off once for a long stretch.
	initial begin : result_sink
		int  mode;
		int  mode_left;
		bit  hold_done;
		mode = 0;
		mode_left = 0;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (backpressure_start && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(5, 40);
			end
			mode_left--;
			case (mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin : stimulus
		int                           i;
		int unsigned                  pick;
		osett_pkg::kind_t             k;
		logic [osett_pkg::ID_W-1:0]   id;
		logic [osett_pkg::TIME_W-1:0] t;
		logic [osett_pkg::TIME_W-1:0] now;
		logic [osett_pkg::ID_W-1:0]   id_pool[16];
		for (i = 0; i < osett_pkg::SLOTS; i++) begin
			tbl_used[i] = 1'b0;
			tbl_event[i] = '0;
			tbl_armed[i] = 1'b0;
			tbl_due[i] = '0;
		end
		for (i = 0; i < 16; i++)
			id_pool[i] = osett_pkg::ID_W'($urandom);
		now = '0;

		add_row(osett_pkg::KIND_TICK,       8'h00, '0,           1'b1, 1'b0, 4'd0);
		add_row(osett_pkg::KIND_SCHEDULE,   8'h55, 64'd5,        1'b1, 1'b0, 4'd0);
		add_row(osett_pkg::KIND_UNREGISTER, 8'hAA, '0,           1'b1, 1'b1, 4'd0);
		add_row(osett_pkg::KIND_REGISTER,   8'h00, '0,           1'b1, 1'b1, 4'd0);
		add_row(osett_pkg::KIND_REGISTER,   8'hFF, TIME_MAX,     1'b1, 1'b1, 4'd1);
		add_row(osett_pkg::KIND_SCHEDULE,   8'h00, '0,           1'b1, 1'b1, 4'd0);
		add_row(osett_pkg::KIND_SCHEDULE,   8'hFF, TIME_MAX,     1'b1, 1'b1, 4'd1);
		add_row(osett_pkg::KIND_TICK,       8'hFF, TIME_MAX - 1, 1'b0, 1'b0, 4'd0);
		add_row(osett_pkg::KIND_SCHEDULE,   8'hFF, 64'd3,        1'b0, 1'b0, 4'd0);
		add_row(osett_pkg::KIND_SCHEDULE,   8'h00, 64'd2,        1'b0, 1'b0, 4'd0);
		add_row(osett_pkg::KIND_TICK,       8'h00, TIME_MAX,     1'b0, 1'b0, 4'd0);
		for (i = 1; i <= 8; i++)
			add_row(osett_pkg::KIND_REGISTER, osett_pkg::ID_W'(i), '0, 1'b0, 1'b0, 4'd0);
		// The table is full now, so this register fails.
		add_row(osett_pkg::KIND_REGISTER,   8'h77, '0,           1'b1, 1'b0, 4'd0);
		add_row(osett_pkg::KIND_UNREGISTER, 8'h00, '0,           1'b1, 1'b1, 4'd0);
		add_row(osett_pkg::KIND_SCHEDULE,   8'h01, 64'd100,      1'b0, 1'b0, 4'd0);
		add_row(osett_pkg::KIND_REGISTER,   8'h01, '0,           1'b0, 1'b0, 4'd0);
		add_row(osett_pkg::KIND_TICK,       8'h00, 64'd200,      1'b0, 1'b0, 4'd0);
		add_row(osett_pkg::KIND_SCHEDULE,   8'h02, 64'd7,        1'b0, 1'b0, 4'd0);
		add_row(osett_pkg::KIND_TICK,       8'h00, 64'd7,        1'b0, 1'b0, 4'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			issue_request(directed_rows[r].k, directed_rows[r].id, directed_rows[r].t,
			              directed_rows[r].typed, directed_rows[r].want);

		for (i = 0; i < RANDOM_COUNT; i++) begin
			if (i == 40)
				backpressure_start = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 30)
				k = osett_pkg::KIND_REGISTER;
			else if (pick < 40)
				k = osett_pkg::KIND_UNREGISTER;
			else if (pick < 75)
				k = osett_pkg::KIND_SCHEDULE;
			else
				k = osett_pkg::KIND_TICK;
			// Most ids come from a small pool so that requests find their slots.
			id = ($urandom_range(0, 4) == 0) ? osett_pkg::ID_W'($urandom)
				: id_pool[4'($urandom_range(0, 15))];
			pick = $urandom_range(0, 99);
			if (k == osett_pkg::KIND_TICK) begin
				if (pick < 75) begin
					now = now + osett_pkg::TIME_W'($urandom_range(0, 400));
					t = now;
				end else if (pick < 85) begin
					t = {$urandom, $urandom};
				end else begin
					t = TIME_MAX - osett_pkg::TIME_W'($urandom_range(0, 3));
				end
			end else begin
				if (pick < 60)
					t = now + osett_pkg::TIME_W'($urandom_range(0, 600));
				else if (pick < 80)
					t = {$urandom, $urandom};
				else
					t = TIME_MAX - osett_pkg::TIME_W'($urandom_range(0, 3));
			end
			issue_request(k, id, t, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_reports.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
